FILE: src/rmh_pkg.sv
// ----------------------------------------------------------------------------
// rmh_pkg: shared types and constants for the running mode histogram
// Fixed field widths of the item ports and the width of the set tag.
// ----------------------------------------------------------------------------
package rmh_pkg;

  localparam int SAMPLE_W     = 14;
  localparam int MODE_COUNT_W = 16;
  localparam int GEN_W        = 8;

  typedef logic [SAMPLE_W-1:0]     sample_t;
  typedef logic [MODE_COUNT_W-1:0] mode_count_t;
  typedef logic [GEN_W-1:0]        gen_t;

  localparam gen_t GEN_LAST = {GEN_W{1'b1}};

endpackage

FILE: src/rmh_count_ram.sv
// ----------------------------------------------------------------------------
// rmh_count_ram: count and tag store of the running mode histogram
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rmh_count_ram #(
  parameter int DEPTH = 16384,
  parameter int DW    = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data
);
  import rmh_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/running_mode_histogram_core.sv
// ----------------------------------------------------------------------------
// running_mode_histogram_core: streaming mode finder over data sets
// Counts each value of a set in a tagged memory and reports the running mode.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid/in_ready, sample_value, last_in_set | input
//   out     | out_valid/out_ready, mode_value, mode_count, set_done | output
//
// One item per cycle while no clearing pass runs and the result is not
// stalled: the read of the count memory is issued when the item is taken,
// and the modify and write happen in the modify stage as the item leaves it,
// with the previous write forwarded when both items hit the same entry.
// After reset, and after the set that uses the last tag value, a clearing
// pass writes every entry, one per cycle; no item is taken meanwhile.
// A stalled result stalls the pipeline in place.
// ----------------------------------------------------------------------------
module running_mode_histogram_core #(
  parameter int VALUE_COUNT = 16384,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rmh_pkg::sample_t     in_sample_value,
  input  logic                 in_last_in_set,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rmh_pkg::sample_t     out_mode_value,
  output rmh_pkg::mode_count_t out_mode_count,
  output logic                 out_set_done
);
  import rmh_pkg::*;

  localparam int AW = $clog2(VALUE_COUNT);
  localparam int CW = COUNT_WIDTH;
  localparam int DW = GEN_W + CW;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
  localparam logic [AW-1:0] LAST_ADDR = AW'(VALUE_COUNT - 1);

  logic           accept;
  logic           s1_adv;
  logic           in_range;

  logic           s1_valid_r;
  logic [AW-1:0]  s1_addr_r;
  sample_t        s1_value_r;
  logic           s1_in_range_r;
  logic           s1_last_r;

  gen_t           gen_r;
  logic           pending_r;
  sample_t        best_value_r;
  logic [CW-1:0]  best_count_r;

  logic           fwd_valid_r;
  logic [AW-1:0]  fwd_addr_r;
  logic [DW-1:0]  fwd_data_r;

  logic           clr_active_r;
  logic [AW-1:0]  clr_addr_r;

  logic           out_valid_r;
  sample_t        out_mode_value_r;
  mode_count_t    out_mode_count_r;
  logic           out_set_done_r;

  logic [DW-1:0]  rd_data;
  logic [DW-1:0]  src_data;
  gen_t           eff_gen;
  logic [CW-1:0]  cnt_old;
  logic [CW-1:0]  cnt_new;
  logic [CW-1:0]  base_count;
  sample_t        base_value;
  logic [CW-1:0]  best_count_nxt;
  sample_t        best_value_nxt;
  logic           wrap_block;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [DW-1:0]  mem_wdata;

  assign in_range = ({1'b0, in_sample_value} < (SAMPLE_W + 1)'(VALUE_COUNT))
                    || (VALUE_COUNT > (1 << SAMPLE_W));

  // Set processing of the item in the modify stage.
  always_comb begin
    eff_gen    = pending_r ? gen_t'(gen_r + 1'b1) : gen_r;
    base_count = pending_r ? '0 : best_count_r;
    base_value = pending_r ? '0 : best_value_r;
    src_data   = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_data;
    cnt_old    = (src_data[DW-1:CW] == eff_gen) ? src_data[CW-1:0] : '0;
    cnt_new    = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;
    best_count_nxt = base_count;
    best_value_nxt = base_value;
    if (s1_in_range_r && (cnt_new > base_count)) begin
      best_count_nxt = cnt_new;
      best_value_nxt = s1_value_r;
    end
  end

  assign s1_adv     = s1_valid_r && (!out_valid_r || out_ready);
  // The next set would reuse tag zero; hold input until the store is cleared.
  assign wrap_block = s1_valid_r && s1_last_r && (eff_gen == GEN_LAST);
  assign in_ready   = !clr_active_r && (!s1_valid_r || s1_adv) && !wrap_block;
  assign accept     = in_valid && in_ready;

  assign mem_we    = clr_active_r || (s1_adv && s1_in_range_r);
  assign mem_waddr = clr_active_r ? clr_addr_r : s1_addr_r;
  assign mem_wdata = clr_active_r ? '0 : {eff_gen, cnt_new};

  rmh_count_ram #(
    .DEPTH (VALUE_COUNT),
    .DW    (DW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (accept),
    .rd_addr (AW'(in_sample_value)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      gen_r        <= '0;
      pending_r    <= 1'b0;
      best_value_r <= '0;
      best_count_r <= '0;
      fwd_valid_r  <= 1'b0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        gen_r        <= eff_gen;
        pending_r    <= s1_last_r;
        best_value_r <= best_value_nxt;
        best_count_r <= best_count_nxt;
        fwd_valid_r  <= s1_in_range_r;
      end

      if (clr_active_r) begin
        fwd_valid_r <= 1'b0;
        if (clr_addr_r == LAST_ADDR) begin
          clr_active_r <= 1'b0;
          clr_addr_r   <= '0;
        end else begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
      end else if (s1_adv && wrap_block) begin
        clr_active_r <= 1'b1;
        clr_addr_r   <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r     <= AW'(in_sample_value);
      s1_value_r    <= in_sample_value;
      s1_in_range_r <= in_range;
      s1_last_r     <= in_last_in_set;
    end
    if (s1_adv) begin
      fwd_addr_r       <= s1_addr_r;
      fwd_data_r       <= {eff_gen, cnt_new};
      out_mode_value_r <= best_value_nxt;
      out_mode_count_r <= MODE_COUNT_W'(best_count_nxt);
      out_set_done_r   <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mode_value = out_mode_value_r;
  assign out_mode_count = out_mode_count_r;
  assign out_set_done   = out_set_done_r;

endmodule

FILE: tb/tb_running_mode_histogram_core.sv
// ----------------------------------------------------------------------------
// tb_running_mode_histogram_core: self-checking bench for the mode finder
// Streams data sets through the core and checks every result against an
// in-bench tally of the current set, covering ties, set restarts, tag wrap,
// random gaps on the input and random back pressure on the output.
// ----------------------------------------------------------------------------
module tb_running_mode_histogram_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rmh_pkg::*;

  localparam int VALUE_COUNT = 16384;
  localparam int COUNT_WIDTH = 16;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;
  // The clearing pass after reset or tag wrap keeps both channels quiet.
  localparam int QUIET_LIMIT = 4 * VALUE_COUNT + 1000;
  localparam sample_t SAMPLE_MAX = {SAMPLE_W{1'b1}};

  typedef struct packed {
    sample_t     mode;
    mode_count_t count;
    logic        done;
  } mode_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  sample_t     in_sample_value;
  logic        in_last_in_set;
  logic        out_valid;
  logic        out_ready;
  sample_t     out_mode_value;
  mode_count_t out_mode_count;
  logic        out_set_done;

  // Running tally of the current set, mirroring the core's state.
  int unsigned tally [VALUE_COUNT];
  gen_t        tally_tag [VALUE_COUNT];
  gen_t        set_tag;
  sample_t     lead_value;
  int unsigned lead_count;
  bit          fresh_set_due;

  mode_result_t expected_modes [$];
  int           mismatches;
  int           quiet_cycles;
  bit           idle_on;
  int           calm_left;

  running_mode_histogram_core #(
    .VALUE_COUNT(VALUE_COUNT),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_value(in_sample_value),
    .in_last_in_set (in_last_in_set),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mode_value (out_mode_value),
    .out_mode_count (out_mode_count),
    .out_set_done   (out_set_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_tally();
    foreach (tally[i]) begin
      tally[i]     = 0;
      tally_tag[i] = '0;
    end
  endfunction

  // Counts one sample into the tally and returns the mode it leaves behind.
  function automatic mode_result_t tally_sample(input sample_t v, input logic last);
    int unsigned  c;
    mode_result_t r;
    if (fresh_set_due) begin
      set_tag = set_tag + 1'b1;
      if (set_tag == '0) begin
        clear_tally();
      end
      lead_value    = '0;
      lead_count    = 0;
      fresh_set_due = 1'b0;
    end
    if (int'(v) < VALUE_COUNT) begin
      c = (tally_tag[v] == set_tag) ? tally[v] : 0;
      if (c < COUNT_MAX) c++;
      tally[v]     = c;
      tally_tag[v] = set_tag;
      // Only a strictly greater count takes over, so ties keep the earlier value.
      if (c > lead_count) begin
        lead_count = c;
        lead_value = v;
      end
    end
    if (last) fresh_set_due = 1'b1;
    r.mode  = lead_value;
    r.count = mode_count_t'(lead_count);
    r.done  = last;
    return r;
  endfunction

  function automatic gen_t upcoming_tag();
    return fresh_set_due ? gen_t'(set_tag + 1'b1) : set_tag;
  endfunction

  task automatic send_sample(input sample_t v, input logic last);
    int n;
    if (calm_left > 0) begin
      calm_left--;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= v;
    in_last_in_set  <= last;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    expected_modes.push_back(tally_sample(v, last));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_modes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // Extremes of the value, ties in both orders, and a fresh set that
    // reuses a value counted in the set before.
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b1);
    send_sample(14'h2AAA, 1'b1);
    send_sample(14'h1555, 1'b0);
    send_sample(14'h2AAA, 1'b0);
    send_sample(14'h2AAA, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(14'h0001, 1'b0);
    send_sample(14'h2000, 1'b1);
    // Every value of 14 bits is in range here, so the out-of-range case
    // cannot be driven with this configuration.
    wait_drained();
  endtask

  task automatic test_forwarding();
    bit saved;
    saved   = idle_on;
    idle_on = 1'b0;
    // Back-to-back hits on one entry, then alternating entries, then a run on one entry across set ends.
    repeat (6) send_sample(14'h0123, 1'b0);
    send_sample(14'h3210, 1'b0);
    send_sample(14'h0123, 1'b0);
    send_sample(14'h3210, 1'b0);
    send_sample(14'h3210, 1'b0);
    send_sample(14'h3210, 1'b0);
    send_sample(14'h3210, 1'b0);
    send_sample(14'h3210, 1'b0);
    send_sample(14'h3210, 1'b1);
    send_sample(14'h3210, 1'b1);
    wait_drained();
    idle_on = saved;
  endtask

  task automatic test_generation_wrap();
    // Each one-item set uses a value tied to its own tag, so a tag that comes
    // round again would see the old count if the wrap did not clear it.
    repeat (260) send_sample({6'b101101, upcoming_tag()}, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_sets(input int n_items);
    sample_t pool [4];
    int      sent;
    int      len;
    int      k;
    sample_t v;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      k   = $urandom_range(1, 4);
      foreach (pool[i]) begin
        case ($urandom_range(0, 5))
          0:       pool[i] = '0;
          1:       pool[i] = SAMPLE_MAX;
          default: pool[i] = sample_t'($urandom_range(0, VALUE_COUNT - 1));
        endcase
      end
      for (int j = 0; j < len; j++) begin
        v = ($urandom_range(0, 9) == 0) ? sample_t'($urandom_range(0, 16383))
                                       : pool[$urandom_range(0, k - 1)];
        send_sample(v, j == len - 1);
      end
      sent += len;
      if ($urandom_range(0, 11) == 0) wait_drained();
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin : ready_gen
      int n;
      if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    mode_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_modes.size() == 0) begin
        mismatches++;
        $error("out_mode_value: expected no item, actual %0d", out_mode_value);
      end else begin
        want = expected_modes.pop_front();
        if (out_mode_value !== want.mode) begin
          mismatches++;
          $error("out_mode_value: expected %0d, actual %0d", want.mode, out_mode_value);
        end
        if (out_mode_count !== want.count) begin
          mismatches++;
          $error("out_mode_count: expected %0d, actual %0d", want.count, out_mode_count);
        end
        if (out_set_done !== want.done) begin
          mismatches++;
          $error("out_set_done: expected %0d, actual %0d", want.done, out_set_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_sample_value <= '0;
    in_last_in_set  <= 1'b0;
    quiet_cycles    = 0;
    mismatches      = 0;
    calm_left       = 0;
    idle_on         = 1'b1;
    clear_tally();
    set_tag       = '0;
    lead_value    = '0;
    lead_count    = 0;
    fresh_set_due = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_forwarding();
    test_generation_wrap();
    test_random_sets(600);
    // The last part of the run turns off the random input gaps and output stalls.
    idle_on   = 1'b0;
    calm_left = 0;
    test_random_sets(150);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_modes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/rmh_pkg.sv
src/rmh_count_ram.sv
src/running_mode_histogram_core.sv
tb/tb_running_mode_histogram_core.sv
